>>> rtl/core/rtc_pkg.sv
package rtc_pkg;

  typedef enum logic [1:0] {
    FN_WEIGHT,
    FN_BIAS,
    FN_INIT,
    FN_ELEM
  } rtc_func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EL_RD,
    ST_EL_MUL,
    ST_EL_ADD,
    ST_RE_ACC,
    ST_RE_RD,
    ST_RE_MUL,
    ST_RE_ADD,
    ST_RE_BIAS,
    ST_RE_RND,
    ST_RE_TAB,
    ST_RE_OUT
  } rtc_state_t;

  localparam logic [2:0] CFG_INPUT_LENGTH       = 3'd0;
  localparam logic [2:0] CFG_HIDDEN_LENGTH      = 3'd1;
  localparam logic [2:0] CFG_BATCH_COUNT        = 3'd2;
  localparam logic [2:0] CFG_SEQUENCE_LENGTH    = 3'd3;
  localparam logic [2:0] CFG_OUTPUT_STEPS       = 3'd4;
  localparam logic [2:0] CFG_USE_BIAS           = 3'd5;
  localparam logic [2:0] CFG_USE_INITIAL_HIDDEN = 3'd6;

  localparam int TAB_W = 11;

endpackage

>>> rtl/core/recurrent_tanh_cell.sv
// Elman RNN cell, h = tanh([x,h].W + b), signed Q4.11, with one shared
// multiply-accumulate unit run by a small sequencer. Items with func weight,
// bias or initial-hidden are written straight into their store. An input
// element does one multiply-accumulate per hidden unit (H = hidden_length),
// each pass reading the weight memory and accumulator memory once. The
// element that closes a batch row is followed by the row end: for each unit
// the old hidden products go through the same multiplier, then bias,
// rounding, saturation and a tanh table lookup.
// During emitting steps each unit's word waits on out_ready before the next
// unit starts. in_ready is low while an item is being worked on. No clearing
// pass is needed after reset; the accumulator reads as zero on a row's first
// element, and at step 0 that first element loads the row's hidden values
// from the initial store or zero.
module recurrent_tanh_cell
  import rtc_pkg::*;
#(
  parameter int IN_MAX       = 64,
  parameter int HID_MAX      = 64,
  parameter int BATCH_MAX    = 8,
  parameter int TANH_ENTRIES = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_func,
  input  logic [12:0]        in_index,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_batch_row,
  output logic [5:0]         out_unit,
  output logic [15:0]        out_step,
  output logic signed [11:0] out_hidden_value,
  output logic               out_last
);

  localparam int WD  = (IN_MAX + HID_MAX) * HID_MAX;
  localparam int WAW = WD > 1 ? $clog2(WD) : 1;
  localparam int UW  = HID_MAX > 1 ? $clog2(HID_MAX) : 1;
  localparam int EW  = IN_MAX > 1 ? $clog2(IN_MAX) : 1;
  localparam int RW  = BATCH_MAX > 1 ? $clog2(BATCH_MAX) : 1;
  localparam int NIW = $clog2(IN_MAX + 1);
  localparam int NHW = $clog2(HID_MAX + 1);
  localparam int NBW = $clog2(BATCH_MAX + 1);
  localparam int HAW = 1 + RW + UW;
  localparam int TW  = $clog2(TANH_ENTRIES);

  // series terms of tanh(8/TANH_ENTRIES) in Q30
  localparam logic [63:0] TY  = ((64'd1 << 33) + 64'(TANH_ENTRIES / 2)) / 64'(TANH_ENTRIES);
  localparam logic [63:0] TY2 = (TY * TY) >> 30;
  localparam logic [63:0] TY3 = (TY2 * TY) >> 30;
  localparam logic [63:0] TY5 = (TY3 * TY2) >> 30;
  localparam logic [63:0] TY7 = (TY5 * TY2) >> 30;
  localparam logic [63:0] TT1 = TY - TY3 / 64'd3 + (64'd2 * TY5) / 64'd15
                                - (64'd17 * TY7) / 64'd315;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q, rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [TANH_ENTRIES*TAB_W-1:0] build_tanh();
    logic [63:0] t, e;
    logic [TANH_ENTRIES*TAB_W-1:0] tab;
    t   = 64'd0;
    tab = '0;
    for (int k = 0; k < TANH_ENTRIES; k++) begin
      e = (t + (64'd1 << 18)) >> 19;
      tab[k*TAB_W +: TAB_W] = (e > 64'd2047) ? 11'd2047 : e[10:0];
      t = udiv64((t + TT1) << 30, (64'd1 << 30) + ((t * TT1) >> 30));
    end
    return tab;
  endfunction

  localparam logic [TANH_ENTRIES*TAB_W-1:0] TANH_TAB = build_tanh();

  // configuration
  logic [6:0]  in_len_r, hid_len_r;
  logic [3:0]  batch_r;
  logic [15:0] seq_len_r, out_steps_r;
  logic        use_bias_r, use_init_r;

  logic [NIW-1:0] ni;
  logic [NHW-1:0] nh;
  logic [NBW-1:0] nb;
  logic [15:0]    ns;

  always_comb begin
    ni = (in_len_r == 7'd0) ? NIW'(1) :
         (32'(in_len_r) > IN_MAX) ? NIW'(IN_MAX) : NIW'(in_len_r);
    nh = (hid_len_r == 7'd0) ? NHW'(1) :
         (32'(hid_len_r) > HID_MAX) ? NHW'(HID_MAX) : NHW'(hid_len_r);
    nb = (batch_r == 4'd0) ? NBW'(1) :
         (32'(batch_r) > BATCH_MAX) ? NBW'(BATCH_MAX) : NBW'(batch_r);
    ns = (seq_len_r == 16'd0) ? 16'd1 : seq_len_r;
  end

  rtc_state_t state_r, state_nxt;
  logic [UW-1:0]  j_r, j_nxt, p_r, p_nxt;
  logic [EW-1:0]  e_r, e_nxt;
  logic [RW-1:0]  r_r, r_nxt;
  logic [15:0]    step_r, step_nxt;
  logic [BATCH_MAX-1:0] bank_r, bank_nxt;
  logic signed [15:0] val_r, val_nxt;
  logic signed [31:0] prod_r, prod_nxt;
  logic signed [39:0] sum_r, sum_nxt;
  logic signed [15:0] q_r, q_nxt;
  logic signed [11:0] hv_r, hv_nxt;

  // memories
  logic              w_we;
  logic [WAW-1:0]    w_waddr, w_raddr;
  logic [15:0]       w_rdata;
  logic              b_we, i_we;
  logic [UW-1:0]     bi_waddr;
  logic [15:0]       b_rdata, i_rdata;
  logic              a_we;
  logic [39:0]       a_wdata, a_rdata;
  logic              h_we;
  logic [HAW-1:0]    h_waddr, h_raddr;
  logic [15:0]       h_wdata, h_rdata;

  rtc_ram #(.WIDTH(16), .DEPTH(WD)) u_weight (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(in_value), .raddr(w_raddr), .rdata(w_rdata)
  );
  rtc_ram #(.WIDTH(16), .DEPTH(HID_MAX)) u_bias (
    .clk, .we(b_we), .waddr(bi_waddr), .wdata(in_value), .raddr(j_r), .rdata(b_rdata)
  );
  rtc_ram #(.WIDTH(16), .DEPTH(HID_MAX)) u_init (
    .clk, .we(i_we), .waddr(bi_waddr), .wdata(in_value), .raddr(j_r), .rdata(i_rdata)
  );
  rtc_ram #(.WIDTH(40), .DEPTH(HID_MAX)) u_acc (
    .clk, .we(a_we), .waddr(j_r), .wdata(a_wdata), .raddr(j_r), .rdata(a_rdata)
  );
  rtc_ram #(.WIDTH(16), .DEPTH(2 ** HAW)) u_hidden (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata)
  );

  logic        in_acc;
  logic        emit;
  logic        init_ld;
  logic        j_last, p_last;
  logic signed [15:0] hval;
  logic signed [39:0] rnd;
  logic signed [28:0] qq;
  logic signed [16:0] qx;
  logic [16:0] mag;
  logic [29:0] scaled;
  logic [TW-1:0] tidx;
  logic [10:0] ent;
  logic [16:0] step_inc;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign emit     = ({1'b0, step_r} + {1'b0, out_steps_r}) >= {1'b0, ns};
  assign j_last   = (32'(j_r) + 1) == 32'(nh);
  assign p_last   = (32'(p_r) + 1) == 32'(nh);
  // first element of a row at step 0 loads the row's starting hidden vector
  assign init_ld  = (state_r == ST_EL_ADD) && (step_r == 16'd0) && (e_r == '0);

  assign w_we     = in_acc && (in_func == FN_WEIGHT) && (32'(in_index) < WD);
  assign w_waddr  = WAW'(in_index);
  assign b_we     = in_acc && (in_func == FN_BIAS) && (32'(in_index) < HID_MAX);
  assign i_we     = in_acc && (in_func == FN_INIT) && (32'(in_index) < HID_MAX);
  assign bi_waddr = UW'(in_index);
  assign h_raddr  = {bank_r[r_r], r_r, p_r};
  assign h_waddr  = init_ld ? {bank_r[r_r], r_r, j_r} : {~bank_r[r_r], r_r, j_r};
  assign h_wdata  = init_ld ? (use_init_r ? i_rdata : 16'd0) : {{4{hv_r[11]}}, hv_r};
  assign a_wdata  = ((e_r == '0) ? 40'sd0 : $signed(a_rdata)) + 40'(prod_r);

  always_comb begin
    if (state_r == ST_EL_RD) begin
      w_raddr = WAW'(32'(e_r) * 32'(nh) + 32'(j_r));
    end else begin
      w_raddr = WAW'((32'(ni) + 32'(p_r)) * 32'(nh) + 32'(j_r));
    end
  end

  always_comb begin
    hval     = $signed(h_rdata);
    rnd      = sum_r + 40'sd1024;
    qq       = 29'(rnd >>> 11);
    qx       = {q_r[15], q_r};
    mag      = qx[16] ? 17'(-qx) : 17'(qx);
    scaled   = 30'(mag) * 30'(TANH_ENTRIES);
    tidx     = (32'(scaled[29:14]) >= TANH_ENTRIES) ? TW'(TANH_ENTRIES - 1)
                                                     : TW'(scaled[29:14]);
    ent      = TANH_TAB[32'(tidx)*TAB_W +: TAB_W];
    step_inc = {1'b0, step_r} + 17'd1;
  end

  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    p_nxt     = p_r;
    e_nxt     = e_r;
    r_nxt     = r_r;
    step_nxt  = step_r;
    bank_nxt  = bank_r;
    val_nxt   = val_r;
    prod_nxt  = prod_r;
    sum_nxt   = sum_r;
    q_nxt     = q_r;
    hv_nxt    = hv_r;
    a_we      = 1'b0;
    h_we      = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_func == FN_ELEM)) begin
          val_nxt   = in_value;
          j_nxt     = '0;
          state_nxt = ST_EL_RD;
        end
      end
      ST_EL_RD: state_nxt = ST_EL_MUL;
      ST_EL_MUL: begin
        prod_nxt  = val_r * $signed(w_rdata);
        state_nxt = ST_EL_ADD;
      end
      ST_EL_ADD: begin
        a_we = 1'b1;
        h_we = init_ld;
        if (!j_last) begin
          j_nxt     = j_r + UW'(1);
          state_nxt = ST_EL_RD;
        end else if (32'(e_r) + 1 < 32'(ni)) begin
          e_nxt     = e_r + EW'(1);
          state_nxt = ST_IDLE;
        end else begin
          e_nxt     = '0;
          j_nxt     = '0;
          state_nxt = ST_RE_ACC;
        end
      end
      ST_RE_ACC: begin
        p_nxt     = '0;
        state_nxt = ST_RE_RD;
      end
      ST_RE_RD: begin
        if (p_r == '0) begin
          sum_nxt = $signed(a_rdata);
        end
        state_nxt = ST_RE_MUL;
      end
      ST_RE_MUL: begin
        prod_nxt  = hval * $signed(w_rdata);
        state_nxt = ST_RE_ADD;
      end
      ST_RE_ADD: begin
        sum_nxt = sum_r + 40'(prod_r);
        if (p_last) begin
          state_nxt = ST_RE_BIAS;
        end else begin
          p_nxt     = p_r + UW'(1);
          state_nxt = ST_RE_RD;
        end
      end
      ST_RE_BIAS: begin
        if (use_bias_r) begin
          sum_nxt = sum_r + (40'($signed(b_rdata)) <<< 11);
        end
        state_nxt = ST_RE_RND;
      end
      ST_RE_RND: begin
        // round half up, then saturate to 16 bits
        if (qq > 29'sd32767) begin
          q_nxt = 16'sd32767;
        end else if (qq < -29'sd32768) begin
          q_nxt = -16'sd32768;
        end else begin
          q_nxt = 16'(qq);
        end
        state_nxt = ST_RE_TAB;
      end
      ST_RE_TAB: begin
        hv_nxt    = q_r[15] ? -$signed({1'b0, ent}) : $signed({1'b0, ent});
        state_nxt = ST_RE_OUT;
      end
      ST_RE_OUT: begin
        h_we      = 1'b1;
        out_valid = emit;
        if (!emit || out_ready) begin
          if (j_last) begin
            bank_nxt[r_r] = ~bank_r[r_r];
            if (32'(r_r) + 1 >= 32'(nb)) begin
              r_nxt    = '0;
              step_nxt = (step_inc >= {1'b0, ns}) ? 16'd0 : step_inc[15:0];
            end else begin
              r_nxt = r_r + RW'(1);
            end
            state_nxt = ST_IDLE;
          end else begin
            j_nxt     = j_r + UW'(1);
            state_nxt = ST_RE_ACC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_batch_row    = 3'(r_r);
  assign out_unit         = 6'(j_r);
  assign out_step         = step_r;
  assign out_hidden_value = hv_r;
  assign out_last         = j_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      p_r         <= '0;
      e_r         <= '0;
      r_r         <= '0;
      step_r      <= '0;
      bank_r      <= '0;
      in_len_r    <= 7'd1;
      hid_len_r   <= 7'd1;
      batch_r     <= 4'd1;
      seq_len_r   <= 16'd1;
      out_steps_r <= 16'd1;
      use_bias_r  <= 1'b0;
      use_init_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
      p_r     <= p_nxt;
      e_r     <= e_nxt;
      r_r     <= r_nxt;
      step_r  <= step_nxt;
      bank_r  <= bank_nxt;
      if (cfg_we && (cfg_index <= CFG_USE_INITIAL_HIDDEN)) begin
        // any register write restarts the sequence
        e_r    <= '0;
        r_r    <= '0;
        step_r <= '0;
        unique case (cfg_index)
          CFG_INPUT_LENGTH:       in_len_r    <= cfg_data[6:0];
          CFG_HIDDEN_LENGTH:      hid_len_r   <= cfg_data[6:0];
          CFG_BATCH_COUNT:        batch_r     <= cfg_data[3:0];
          CFG_SEQUENCE_LENGTH:    seq_len_r   <= cfg_data;
          CFG_OUTPUT_STEPS:       out_steps_r <= cfg_data;
          CFG_USE_BIAS:           use_bias_r  <= cfg_data[0];
          CFG_USE_INITIAL_HIDDEN: use_init_r  <= cfg_data[0];
          default:                ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    prod_r <= prod_nxt;
    sum_r  <= sum_nxt;
    q_r    <= q_nxt;
    hv_r   <= hv_nxt;
  end

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("result shown while accepting");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EL_ADD) |-> (32'(j_r) < 32'(nh))) else $error("unit past hidden length");

  a_last_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_unit == 6'(32'(nh) - 1)))
    else $error("last flag on wrong unit");

  a_elem_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_func == FN_ELEM) && !cfg_we) |=> (state_r == ST_EL_RD))
    else $error("element not started");

endmodule

>>> rtl/core/rtc_ram.sv
module rtc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
